@@ design/ate_pkg.sv @@
// Shared constants, the arctangent table and the smoothing function of the tilt estimator.
package ate_pkg;

  localparam int SampleWidthDef = 16;
  localparam int CordicStepsDef = 16;
  localparam int AngW = 15;
  localparam int ZW = 26;
  localparam int AlphaW = 9;
  localparam int CfgIdxW = 1;
  localparam int FracShift = 16;
  localparam int AngLimit = 11520;

  localparam logic [CfgIdxW-1:0] CfgAlpha = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSign = 1'b1;

  localparam logic [1:0] FilterKeep = 2'd0;
  localparam logic [1:0] FilterOff = 2'd1;
  localparam logic [1:0] FilterOn = 2'd2;
  localparam logic [1:0] FilterSpare = 2'd3;

  localparam logic [AlphaW-1:0] AlphaReset = 9'd51;
  localparam logic [AlphaW-1:0] AlphaMax = 9'd256;
  localparam logic [AlphaW-1:0] PitchWeight = 9'd230;

  // Arctangent of 2^-i in units of 2^-16 degree.
  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0: v = 26'sd2949120;
      1: v = 26'sd1740967;
      2: v = 26'sd919879;
      3: v = 26'sd466945;
      4: v = 26'sd234379;
      5: v = 26'sd117304;
      6: v = 26'sd58666;
      7: v = 26'sd29335;
      8: v = 26'sd14668;
      9: v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

  // Weighted mix of a fresh and an old angle with Q1.8 weight w, rounded and floored.
  function automatic logic signed [AngW-1:0] blend(input logic signed [AngW-1:0] fresh,
                                                   input logic signed [AngW-1:0] old,
                                                   input logic [AlphaW-1:0] w);
    logic signed [AlphaW:0] wn;
    logic signed [AlphaW:0] wo;
    logic signed [AngW+AlphaW+1:0] acc;
    wn = $signed({1'b0, w});
    wo = 10'sd256 - wn;
    acc = fresh * wn + old * wo + 26'sd128;
    return acc[AngW+7:8];
  endfunction

endpackage

@@ design/ate_in_if.sv @@
// Input channel carrying one accelerometer sample and a filter request.
interface ate_in_if #(
  parameter int SAMPLE_WIDTH = ate_pkg::SampleWidthDef
);
  logic valid;
  logic ready;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;
  logic [1:0] filter_request;

  modport source(output valid, accel_x, accel_y, accel_z, filter_request, input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, filter_request, output ready);
endinterface

@@ design/ate_out_if.sv @@
// Output channel carrying the roll and pitch orientation of one sample.
interface ate_out_if;
  logic valid;
  logic ready;
  logic signed [ate_pkg::AngW-1:0] roll_out;
  logic signed [ate_pkg::AngW-1:0] pitch_out;
  logic filter_active;

  modport source(output valid, roll_out, pitch_out, filter_active, input ready);
  modport sink(input valid, roll_out, pitch_out, filter_active, output ready);
endinterface

@@ design/ate_sqrt.sv @@
// Iterative floor square root that settles one result bit from each two bits of the operand.
module ate_sqrt #(
  parameter int OPW = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [OPW-1:0]       op_i,
  output logic                 done_o,
  output logic [OPW/2-1:0]     root_o
);
  localparam int RW = OPW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [OPW-1:0] op_q, op_d;
  logic [RW+1:0] rem_q, rem_d;
  logic [RW-1:0] root_q, root_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [RW+3:0] cat;
  logic [RW+3:0] trial;
  logic ge;

  assign cat = {rem_q, op_q[OPW-1:OPW-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge = cat >= trial;

  always_comb begin
    op_d = op_q;
    rem_d = rem_q;
    root_d = root_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      op_d = op_i;
      rem_d = '0;
      root_d = '0;
      cnt_d = CW'(RW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      op_d = {op_q[OPW-3:0], 2'b00};
      rem_d = ge ? (RW+2)'(cat - trial) : (RW+2)'(cat);
      root_d = {root_q[RW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    rem_q <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

@@ design/ate_cell.sv @@
// One vectoring rotation step for the pitch and roll lanes, registered toward the next cell.
module ate_cell #(
  parameter int XW = 27,
  parameter int STEP = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [XW-1:0]           x_i [2],
  input  logic signed [XW-1:0]           y_i [2],
  input  logic signed [ate_pkg::ZW-1:0]  z_i [2],
  output logic                           valid_o,
  output logic signed [XW-1:0]           x_o [2],
  output logic signed [XW-1:0]           y_o [2],
  output logic signed [ate_pkg::ZW-1:0]  z_o [2]
);
  localparam logic signed [ate_pkg::ZW-1:0] Ang = ate_pkg::atan_entry(STEP);

  logic valid_q;
  logic signed [XW-1:0] x_q [2];
  logic signed [XW-1:0] y_q [2];
  logic signed [ate_pkg::ZW-1:0] z_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (!y_i[l][XW-1]) begin
        x_q[l] <= x_i[l] + (y_i[l] >>> STEP);
        y_q[l] <= y_i[l] - (x_i[l] >>> STEP);
        z_q[l] <= z_i[l] + Ang;
      end else begin
        x_q[l] <= x_i[l] - (y_i[l] >>> STEP);
        y_q[l] <= y_i[l] + (x_i[l] >>> STEP);
        z_q[l] <= z_i[l] - Ang;
      end
    end
  end

  assign valid_o = valid_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

@@ design/accel_tilt_estimator.sv @@
// Top level of the accelerometer tilt estimator with smoothing and orientation output.
//
// A sample word enters on in_i when valid and ready are both high; ready is high only
// while the block is idle. Each axis above 1 g is clamped to 0.99 g, the squares are
// formed, two floor square roots run, and the pitch and roll vectors then pass
// through a row of CORDIC_STEPS rotation cells. Rounding, two smoothing steps and
// the sign correction follow. One sample is worked on at a time, so a new sample is
// only taken once the result of the last one is in the output register.
// The result word waits in an output register on out_o until taken. The next sample
// is accepted while it waits, but its own result is held back until the register is
// free. The cfg port writes alpha and sign_correct, and should be used only while idle.
// Reset turns filtering off, clears all smoothing state, sets alpha to 51 and
// sign_correct to 0, and leaves the output channel empty.
module accel_tilt_estimator #(
  parameter int SAMPLE_WIDTH = ate_pkg::SampleWidthDef,
  parameter int CORDIC_STEPS = ate_pkg::CordicStepsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ate_in_if.sink                         in_i,
  ate_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [ate_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ate_pkg::AlphaW-1:0]     cfg_data_i
);
  localparam int W = SAMPLE_WIDTH;
  localparam int OPW = 2 * W + ate_pkg::FracShift;
  localparam int RW = OPW / 2;
  localparam int XW = W + 11;
  localparam int ZW = ate_pkg::ZW;
  localparam int AW = ate_pkg::AngW;
  localparam logic signed [W-1:0] OneG = W'(1 << (W - 2));
  localparam logic signed [W-1:0] ClampG = W'((99 * (1 << (W - 2)) + 50) / 100);
  localparam logic signed [ZW-10:0] Lim = (ZW-9)'(ate_pkg::AngLimit);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_CORD = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_F1 = 3'd5;
  localparam logic [2:0] S_F2 = 3'd6;
  localparam logic [2:0] S_OUT = 3'd7;

  logic [2:0] state_q, state_d;
  logic [ate_pkg::AlphaW-1:0] alpha_q;
  logic sign_q;
  logic filt_q;
  logic signed [W-1:0] ax_q, ay_q, az_q;
  logic [2*W-1:0] sqx_q, sqy_q, sqz_q;
  logic [2*W-1:0] sum_p, sum_r;
  logic zero_p_q, zero_r_q;
  logic start;
  logic done_p, done_r;
  logic [RW-1:0] root_p, root_r;
  logic signed [AW-1:0] ang_p_q, ang_r_q;
  logic signed [AW-1:0] sm_p_q, sm_r_q, or_p_q, or_r_q;
  logic out_valid_q;
  logic signed [AW-1:0] out_roll_q, out_pitch_q;
  logic out_filt_q;
  logic [ate_pkg::AlphaW-1:0] w_eff;
  logic signed [AW-1:0] roll_fix;
  logic out_load;

  logic chain_v [CORDIC_STEPS+1];
  logic signed [XW-1:0] chain_x [CORDIC_STEPS+1][2];
  logic signed [XW-1:0] chain_y [CORDIC_STEPS+1][2];
  logic signed [ZW-1:0] chain_z [CORDIC_STEPS+1][2];

  assign in_i.ready = (state_q == S_IDLE);
  assign sum_p = sqx_q + sqz_q;
  assign sum_r = sqy_q + sqz_q;
  assign w_eff = (alpha_q > ate_pkg::AlphaMax) ? ate_pkg::AlphaMax : alpha_q;
  assign start = (state_q == S_SQ);
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);
  assign roll_fix = (sign_q && !(or_p_q > 0)) ? -or_r_q : or_r_q;

  ate_sqrt #(.OPW(OPW)) u_sqrt_p (
    .clk_i, .rst_ni, .start_i(start), .op_i({sum_p, 16'h0000}),
    .done_o(done_p), .root_o(root_p)
  );
  ate_sqrt #(.OPW(OPW)) u_sqrt_r (
    .clk_i, .rst_ni, .start_i(start), .op_i({sum_r, 16'h0000}),
    .done_o(done_r), .root_o(root_r)
  );

  assign chain_v[0] = done_p;
  assign chain_x[0][0] = XW'(root_p);
  assign chain_x[0][1] = XW'(root_r);
  assign chain_y[0][0] = $signed({{(XW-W){ay_q[W-1]}}, ay_q}) <<< 8;
  assign chain_y[0][1] = (-$signed({{(XW-W){ax_q[W-1]}}, ax_q})) <<< 8;
  assign chain_z[0][0] = '0;
  assign chain_z[0][1] = '0;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    ate_cell #(.XW(XW), .STEP(g)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(chain_v[g]), .x_i(chain_x[g]), .y_i(chain_y[g]), .z_i(chain_z[g]),
      .valid_o(chain_v[g+1]), .x_o(chain_x[g+1]), .y_o(chain_y[g+1]), .z_o(chain_z[g+1])
    );
  end

  function automatic logic signed [AW-1:0] round_sat(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] zs;
    logic signed [ZW-10:0] r;
    zs = z + ZW'(256);
    r = zs[ZW-1:9];
    if (r > Lim) begin
      r = Lim;
    end else if (r < -Lim) begin
      r = -Lim;
    end
    return r[AW-1:0];
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_i.valid) state_d = S_SQ;
      S_SQ: state_d = S_ROOT;
      S_ROOT: if (done_p) state_d = S_CORD;
      S_CORD: if (chain_v[CORDIC_STEPS]) state_d = S_ROUND;
      S_ROUND: state_d = S_F1;
      S_F1: state_d = S_F2;
      S_F2: state_d = S_OUT;
      S_OUT: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      alpha_q <= ate_pkg::AlphaReset;
      sign_q <= 1'b0;
      filt_q <= 1'b0;
      sm_p_q <= '0;
      sm_r_q <= '0;
      or_p_q <= '0;
      or_r_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ate_pkg::CfgAlpha: alpha_q <= cfg_data_i;
          ate_pkg::CfgSign: sign_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        if (in_i.filter_request == ate_pkg::FilterOff) begin
          filt_q <= 1'b0;
        end else if (in_i.filter_request == ate_pkg::FilterOn) begin
          filt_q <= 1'b1;
        end
      end
      if (state_q == S_F1) begin
        sm_p_q <= filt_q ? ate_pkg::blend(ang_p_q, sm_p_q, w_eff) : ang_p_q;
        sm_r_q <= filt_q ? ate_pkg::blend(ang_r_q, sm_r_q, w_eff) : ang_r_q;
      end
      if (state_q == S_F2) begin
        or_p_q <= filt_q ? ate_pkg::blend(sm_p_q, or_p_q, ate_pkg::PitchWeight) : sm_p_q;
        or_r_q <= filt_q ? ate_pkg::blend(sm_r_q, or_r_q, w_eff) : sm_r_q;
      end
      if (out_load) begin
        or_r_q <= roll_fix;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ax_q <= (in_i.accel_x > OneG) ? ClampG : in_i.accel_x;
      ay_q <= (in_i.accel_y > OneG) ? ClampG : in_i.accel_y;
      az_q <= (in_i.accel_z > OneG) ? ClampG : in_i.accel_z;
    end
    if (state_q == S_IDLE) begin
      sqx_q <= (2*W)'((in_i.accel_x > OneG) ? ClampG * ClampG : in_i.accel_x * in_i.accel_x);
      sqy_q <= (2*W)'((in_i.accel_y > OneG) ? ClampG * ClampG : in_i.accel_y * in_i.accel_y);
      sqz_q <= (2*W)'((in_i.accel_z > OneG) ? ClampG * ClampG : in_i.accel_z * in_i.accel_z);
    end
    if (state_q == S_SQ) begin
      zero_p_q <= (sum_p == '0);
      zero_r_q <= (sum_r == '0);
    end
    if (state_q == S_CORD && chain_v[CORDIC_STEPS]) begin
      ang_p_q <= zero_p_q ? '0 : round_sat(chain_z[CORDIC_STEPS][0]);
      ang_r_q <= zero_r_q ? '0 : round_sat(chain_z[CORDIC_STEPS][1]);
    end
    if (out_load) begin
      out_roll_q <= roll_fix;
      out_pitch_q <= or_p_q;
      out_filt_q <= filt_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.roll_out = out_roll_q;
  assign out_o.pitch_out = out_pitch_q;
  assign out_o.filter_active = out_filt_q;

`ifndef NO_ASSERTIONS
  a_root_in_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_p |-> (state_q == S_ROOT && done_r))
    else $error("square root finished outside its phase");
  a_chain_in_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_v[CORDIC_STEPS] |-> (state_q == S_CORD))
    else $error("cell row delivered outside its phase");
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_pitch_q <= 15'sd11520 && out_pitch_q >= -15'sd11520))
    else $error("pitch out of range");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_pitch_q)))
    else $error("pending result word overwritten");
`endif
endmodule

@@ bench/accel_tilt_estimator_test.sv @@
// Self-checking testbench of the accelerometer tilt estimator with a predicting scoreboard.
module accel_tilt_estimator_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [ate_pkg::AngW-1:0] roll;
    logic signed [ate_pkg::AngW-1:0] pitch;
    logic                   active;
  } tilt_word_t;

  class tilt_scoreboard;
    tilt_word_t   pending_q[$];
    longint       smooth_pitch, smooth_roll, orient_pitch, orient_roll;
    bit           filter_on;
    logic [ate_pkg::AlphaW-1:0] alpha;
    bit           sign_fix;
    int           mismatches;

    function void reset_state();
      smooth_pitch = 0;
      smooth_roll = 0;
      orient_pitch = 0;
      orient_roll = 0;
      filter_on = 0;
      alpha = ate_pkg::AlphaReset;
      sign_fix = 0;
    endfunction

    function longint unsigned floor_root(longint unsigned n);
      longint unsigned res;
      longint unsigned one;
      res = 0;
      one = 64'd1 << 62;
      while (one > n) one = one >> 2;
      while (one != 0) begin
        if (n >= res + one) begin
          n = n - (res + one);
          res = (res >> 1) + one;
        end else begin
          res = res >> 1;
        end
        one = one >> 2;
      end
      return res;
    endfunction

    // Angle of num over the length of (a, b), in 1/128 degree.
    function longint tilt_angle(longint num, longint a, longint b);
      longint unsigned sq;
      longint x, y, z, dx, dy, r;
      sq = a * a + b * b;
      if (sq == 0) return 0;
      x = floor_root(sq << 16);
      y = num * 256;
      z = 0;
      for (int i = 0; i < ate_pkg::CordicStepsDef; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_table(i);
        end else begin
          x -= dx; y += dy; z -= atan_table(i);
        end
      end
      r = (z + 256) >>> 9;
      if (r > ate_pkg::AngLimit) r = ate_pkg::AngLimit;
      if (r < -ate_pkg::AngLimit) r = -ate_pkg::AngLimit;
      return r;
    endfunction

    function longint atan_table(int i);
      longint tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
      return tab[i];
    endfunction

    function longint mix(longint fresh, longint old, longint w);
      return (w * fresh + (256 - w) * old + 128) >>> 8;
    endfunction

    function longint clamp_g(logic signed [15:0] v);
      if (v > 16384) return 16220;
      return v;
    endfunction

    function void note_sample(logic signed [15:0] ax_in, logic signed [15:0] ay_in,
                              logic signed [15:0] az_in, logic [1:0] req);
      longint ax, ay, az, w, pitch, roll;
      tilt_word_t word;
      ax = clamp_g(ax_in);
      ay = clamp_g(ay_in);
      az = clamp_g(az_in);
      w = (alpha > ate_pkg::AlphaMax) ? 256 : longint'(alpha);
      if (req == ate_pkg::FilterOff) filter_on = 0;
      else if (req == ate_pkg::FilterOn) filter_on = 1;
      pitch = tilt_angle(ay, ax, az);
      roll = tilt_angle(-ax, ay, az);
      if (filter_on) begin
        smooth_pitch = mix(pitch, smooth_pitch, w);
        smooth_roll = mix(roll, smooth_roll, w);
        orient_pitch = mix(smooth_pitch, orient_pitch, ate_pkg::PitchWeight);
        orient_roll = mix(smooth_roll, orient_roll, w);
      end else begin
        smooth_pitch = pitch;
        smooth_roll = roll;
        orient_pitch = pitch;
        orient_roll = roll;
      end
      if (sign_fix) orient_roll = (orient_pitch > 0) ? orient_roll : -orient_roll;
      word.roll = orient_roll[ate_pkg::AngW-1:0];
      word.pitch = orient_pitch[ate_pkg::AngW-1:0];
      word.active = filter_on;
      pending_q.push_back(word);
    endfunction

    function void check_word(logic signed [ate_pkg::AngW-1:0] roll,
                             logic signed [ate_pkg::AngW-1:0] pitch, logic active);
      tilt_word_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: roll %0d pitch %0d", roll, pitch);
        return;
      end
      want = pending_q.pop_front();
      if (want.roll !== roll || want.pitch !== pitch || want.active !== active) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected roll %0d pitch %0d active %0d, got %0d %0d %0d",
                   want.roll, want.pitch, want.active, roll, pitch, active);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i = 1'b0;
  logic [ate_pkg::CfgIdxW-1:0] cfg_idx_i = ate_pkg::CfgAlpha;
  logic [ate_pkg::AlphaW-1:0] cfg_data_i = '0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;
  tilt_scoreboard sb;

  ate_in_if in_if ();
  ate_out_if out_if ();

  accel_tilt_estimator i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_if),
    .out_o(out_if),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.accel_x = '0;
    in_if.accel_y = '0;
    in_if.accel_z = '0;
    in_if.filter_request = ate_pkg::FilterKeep;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_word(out_if.roll_out, out_if.pitch_out, out_if.filter_active);
  end

  task automatic send_word(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic [1:0] req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.accel_x <= x;
    in_if.accel_y <= y;
    in_if.accel_z <= z;
    in_if.filter_request <= req;
    @(posedge clk_i iff in_if.ready);
    sb.note_sample(x, y, z, req);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_config(logic [ate_pkg::AlphaW-1:0] alpha, bit sign_fix);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= ate_pkg::CfgAlpha;
    cfg_data_i <= alpha;
    @(posedge clk_i);
    cfg_idx_i <= ate_pkg::CfgSign;
    cfg_data_i <= ate_pkg::AlphaW'(sign_fix);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.alpha = alpha;
    sb.sign_fix = sign_fix;
  endtask

  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(18000, 14000));
      2: return -16'($urandom_range(18000, 14000));
      default: return 16'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic logic [1:0] pick_request();
    int r;
    r = $urandom_range(99);
    if (r < 70) return ate_pkg::FilterKeep;
    if (r < 80) return ate_pkg::FilterOff;
    if (r < 95) return ate_pkg::FilterOn;
    return ate_pkg::FilterSpare;
  endfunction

  initial begin
    logic [ate_pkg::AlphaW-1:0] alphas[4] = '{9'd0, 9'd256, 9'd511, 9'd0};
    int idles[4] = '{0, 81, 0, 25};
    int stalls[4] = '{0, 0, 81, 25};
    rst_ni = 1'b0;
    sb = new();
    sb.reset_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(16'sd0, 16'sd0, 16'sd0, ate_pkg::FilterKeep);
    send_word(16'sd0, 16'sd16384, 16'sd0, ate_pkg::FilterKeep);
    send_word(16'sd32767, 16'sd0, 16'sd0, ate_pkg::FilterKeep);
    send_word(16'sh8000, 16'sd0, 16'sd0, ate_pkg::FilterKeep);
    send_word(16'sd0, 16'sh8000, 16'sd0, ate_pkg::FilterKeep);
    send_word(16'sd16385, 16'sd16384, 16'sd32767, ate_pkg::FilterOn);
    send_word(16'sh8000, 16'sh8000, 16'sh8000, ate_pkg::FilterKeep);
    send_word(16'sd32767, 16'sd32767, 16'sd32767, ate_pkg::FilterSpare);
    send_word(16'sd100, -16'sd9000, 16'sd12000, ate_pkg::FilterKeep);
    send_word(16'sd0, 16'sd0, 16'sd0, ate_pkg::FilterOff);
    send_word(-16'sd1, 16'sd1, 16'sd0, ate_pkg::FilterSpare);
    send_word(16'sd4000, 16'sd4000, -16'sd16384, ate_pkg::FilterOn);
    drain();
    write_config(9'd51, 1'b1);
    send_word(16'sd0, -16'sd5000, 16'sd16000, ate_pkg::FilterKeep);
    send_word(16'sd3000, 16'sd0, 16'sd0, ate_pkg::FilterKeep);
    send_word(-16'sd3000, 16'sd5000, 16'sd10000, ate_pkg::FilterOff);
    send_word(16'sd3000, 16'sd0, 16'sd0, ate_pkg::FilterKeep);

    for (int p = 0; p < 4; p++) begin
      drain();
      write_config(p == 3 ? 9'($urandom_range(511)) : alphas[p], p % 2 == 0);
      send_idle_pct = idles[p];
      recv_stall_pct = stalls[p];
      for (int n = 0; n < 200; n++) begin
        if (n == 100 && p == 0) begin
          in_if.valid <= 1'b0;
          @(posedge clk_i);
          while (sb.pending_q.size() != 0) @(posedge clk_i);
        end
        send_word(pick_axis(), pick_axis(), pick_axis(), pick_request());
      end
    end
    recv_stall_pct = 0;
    drain();
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
